// File: hw/rtl/nesev_pkg.sv
// Shared types, constants and helpers of the NAND expression stack evaluator.
package nesev_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int SYMBOL_W    = 8;
    localparam int VAR_W       = 26;
    localparam int VAR_IDX_W   = 5;
    localparam int OUT_DATA_W  = 8;

    localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h29;
    localparam logic [SYMBOL_W-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYMBOL_W-1:0] SYM_A     = 8'h61;
    localparam logic [SYMBOL_W-1:0] SYM_Z     = 8'h7A;

    // Stack entry: bit 1 marks a filled entry, bit 0 carries its value.
    typedef logic [1:0] entry_t;
    localparam entry_t ENTRY_EMPTY = 2'b00;
    localparam entry_t ENTRY_FULL  = 2'b10;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_OPERAND
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     bit_val;
        logic     last;
    } step_t;

    typedef struct packed {
        logic               value;
        logic               present;
        logic               overflow;
        logic [COUNT_W-1:0] depth;
    } report_t;

    // Folds an incoming entry into a target entry with NAND.
    function automatic entry_t merge_entry(entry_t target, entry_t incoming);
        entry_t res;
        if (!target[1]) begin
            res = incoming;
        end else if (!incoming[1]) begin
            res = ENTRY_FULL | 2'b01;
        end else begin
            res = ENTRY_FULL | {1'b0, ~(target[0] & incoming[0])};
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/nand_expression_stack_evaluator_top.sv
// Top level of the NAND expression stack evaluator.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata = symbol, s_tlast = end_of_formula
//  m_       out  m_tvalid/m_tready  m_tdata = value, value_present, overflow
//  cfg_     in   cfg_valid/cfg_ready cfg_data = variable_bits (a in bit 0)
//
// One character beat is taken every clock cycle while no stalled result holds
// it; the stack update for a character is a single register-to-register step
// on a flip-flop shift stack. A result beat is registered on m_ once the
// formula's last beat has stepped the stack. Reset is synchronous and active
// low; it leaves a single empty stack entry and the variable bits at zero. A
// stalled result holds only a formula's end and what follows; earlier characters flow.
module nand_expression_stack_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input characters.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nesev_pkg::SYMBOL_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                          s_tlast,
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nesev_pkg::OUT_DATA_W-1:0] m_tdata, // [0] value, [1] value_present,
                                                      // [2] overflow, [7:3] zero
    // Variable truth values.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nesev_pkg::VAR_W-1:0]   cfg_data
);
    import nesev_pkg::*;

    // Input register stage.
    logic                 in_valid_reg;
    logic [SYMBOL_W-1:0]  in_symbol_reg;
    logic                 in_last_reg;

    // Result register stage.
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [VAR_W-1:0]     var_bits_reg;

    logic                 out_free;
    logic                 advance;
    logic [SYMBOL_W-1:0]  letter_offset;
    step_t                step;
    report_t              report;

    // A character steps the stack when it exists, unless it ends a formula
    // and the previous result still waits in the output register with m_tready low.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_bits_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            var_bits_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_symbol_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
    end

    // Character decode. Anything that is not a bracket, a space or a
    // lowercase letter is an operand that reads zero.
    assign letter_offset = in_symbol_reg - SYM_A;

    always_comb begin
        step.last    = in_last_reg;
        step.bit_val = 1'b0;
        priority if (in_symbol_reg == SYM_OPEN) begin
            step.kind = OP_PUSH;
        end else if (in_symbol_reg == SYM_CLOSE) begin
            step.kind = OP_POP;
        end else if (in_symbol_reg == SYM_SPACE) begin
            step.kind = OP_NONE;
        end else begin
            step.kind = OP_OPERAND;
            if (in_symbol_reg >= SYM_A && in_symbol_reg <= SYM_Z) begin
                step.bit_val = var_bits_reg[letter_offset[VAR_IDX_W-1:0]];
            end
        end
    end

    nesev_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .step    (step),
        .report  (report)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg <= {{(OUT_DATA_W-3){1'b0}},
                             report.overflow, report.present, report.value};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // A new character never lands on one that has not yet stepped the stack.
    a_no_input_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && in_valid_reg) |-> advance)
        else $error("input stage overwritten before stepping");

    // The end of a formula always produces a result beat.
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("formula end produced no result");

    // After a formula ends the next one starts on a single entry.
    a_stack_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (report.depth == COUNT_W'(1)))
        else $error("stack not restarted after formula end");

    // The stack depth stays within one and the stack size.
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (report.depth >= COUNT_W'(1)) && (report.depth <= COUNT_W'(STACK_DEPTH)))
        else $error("stack depth out of range");
`endif

endmodule

// File: hw/rtl/nesev_stack.sv
// Register stack of empty-or-bit entries with push, pop-and-merge and top update.
module nesev_stack (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  nesev_pkg::step_t  step,
    output nesev_pkg::report_t report
);
    import nesev_pkg::*;

    entry_t               top_reg, top_next;
    entry_t               below_reg  [STACK_DEPTH-1];
    entry_t               below_next [STACK_DEPTH-1];
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    entry_t               top_after;
    logic [COUNT_W-1:0]   count_after;

    always_comb begin
        top_after   = top_reg;
        count_after = count_reg;
        ovf_next    = ovf_reg;
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            below_next[i] = below_reg[i];
        end
        unique case (step.kind)
            OP_PUSH: begin
                if (count_reg < COUNT_W'(STACK_DEPTH)) begin
                    top_after     = ENTRY_EMPTY;
                    below_next[0] = top_reg;
                    for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                        below_next[i] = below_reg[i-1];
                    end
                    count_after = count_reg + COUNT_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
            OP_POP: begin
                if (count_reg > COUNT_W'(1)) begin
                    top_after = merge_entry(below_reg[0], top_reg);
                    for (int i = 0; i < STACK_DEPTH - 2; i++) begin
                        below_next[i] = below_reg[i+1];
                    end
                    count_after = count_reg - COUNT_W'(1);
                end
            end
            OP_OPERAND: begin
                top_after = merge_entry(top_reg, ENTRY_FULL | {1'b0, step.bit_val});
            end
            default: begin
            end
        endcase

        report.value    = top_after[1] & top_after[0];
        report.present  = top_after[1];
        report.overflow = ovf_next;
        report.depth    = count_reg;

        // The last character of a formula returns the stack to one empty entry.
        if (step.last) begin
            top_next   = ENTRY_EMPTY;
            count_next = COUNT_W'(1);
        end else begin
            top_next   = top_after;
            count_next = count_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= ENTRY_EMPTY;
            count_reg <= COUNT_W'(1);
            ovf_reg   <= 1'b0;
        end else if (step_en) begin
            top_reg   <= top_next;
            count_reg <= count_next;
            ovf_reg   <= step.last ? 1'b0 : ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                below_reg[i] <= below_next[i];
            end
        end
    end

endmodule

// File: sim/tb.sv
// Testbench for the NAND expression stack evaluator: streamed formulas checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import nesev_pkg::*;

    typedef struct packed {
        logic value;
        logic present;
        logic overflow;
    } outcome_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SYMBOL_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [VAR_W-1:0]      cfg_data  = '0;

    // Predictor state.
    entry_t           eval_stack [STACK_DEPTH];
    int               eval_depth    = 1;
    logic             eval_overflow = 1'b0;
    logic [VAR_W-1:0] var_bits      = '0;
    outcome_t         expected_outcomes[$];

    int error_count  = 0;
    int symbols_sent = 0;
    bit sender_burst = 1'b0;

    // Result side pacing.
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int sink_gap     = 0;
    bit sink_burst   = 1'b0;

    nand_expression_stack_evaluator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

    // An empty incoming entry counts as not 1, so a filled target becomes 1.
    function automatic entry_t fold_entry(entry_t target, entry_t incoming);
        entry_t res;
        if (!target[1]) begin
            res = incoming;
        end else begin
            res = {1'b1, !(incoming[1] && incoming[0] && target[0])};
        end
        return res;
    endfunction

    function automatic void step_evaluator(logic [SYMBOL_W-1:0] sym, logic last);
        entry_t   operand;
        outcome_t result;
        int       top;
        top = eval_depth - 1;
        if (sym == SYM_OPEN) begin
            if (eval_depth < STACK_DEPTH) begin
                eval_stack[eval_depth] = ENTRY_EMPTY;
                eval_depth++;
            end else begin
                eval_overflow = 1'b1;
            end
        end else if (sym == SYM_CLOSE) begin
            if (eval_depth > 1) begin
                eval_stack[top-1] = fold_entry(eval_stack[top-1], eval_stack[top]);
                eval_depth--;
            end
        end else if (sym != SYM_SPACE) begin
            operand = ENTRY_FULL;
            if (sym >= SYM_A && sym <= SYM_Z) begin
                operand[0] = var_bits[VAR_IDX_W'(sym - SYM_A)];
            end
            eval_stack[top] = fold_entry(eval_stack[top], operand);
        end
        if (last) begin
            result.present  = eval_stack[eval_depth-1][1];
            result.value    = result.present & eval_stack[eval_depth-1][0];
            result.overflow = eval_overflow;
            expected_outcomes.push_back(result);
            for (int i = 0; i < STACK_DEPTH; i++) begin
                eval_stack[i] = ENTRY_EMPTY;
            end
            eval_depth    = 1;
            eval_overflow = 1'b0;
        end
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 50) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        end
    endfunction

    // Result checker; also draws the receiver's wait before the next result beat.
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= 50) begin
                    $display("%0t: result beat %0h with no formula pending", $time, m_tdata);
                end
            end else begin
                want = expected_outcomes.pop_front();
                compare_field("value", 8'(want.value), 8'(m_tdata[0]));
                compare_field("value_present", 8'(want.present), 8'(m_tdata[1]));
                compare_field("overflow", 8'(want.overflow), 8'(m_tdata[2]));
                compare_field("reserved bits", 8'h00, 8'(m_tdata[7:3]));
            end
            if ($urandom_range(0, 15) == 0) begin
                sink_burst = !sink_burst;
            end
            sink_gap = sink_burst ? 0 : $urandom_range(0, 14);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        step_evaluator(sym, last);
        symbols_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_symbol(text[i], i == text.len() - 1);
        end
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() > 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        if (expected_outcomes.size() > 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, expected_outcomes.size());
            expected_outcomes.delete();
        end
        // Non-final characters may still be in the pipeline.
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_variables(input logic [VAR_W-1:0] bits);
        cfg_valid <= 1'b1;
        cfg_data  <= bits;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        var_bits = bits;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SYMBOL_W-1:0] random_operand();
        logic [SYMBOL_W-1:0] sym;
        if ($urandom_range(0, 7) == 0) begin
            sym = SYMBOL_W'($urandom_range(0, 255));
        end else begin
            sym = SYM_A + SYMBOL_W'($urandom_range(0, 25));
        end
        return sym;
    endfunction

    // Balanced formula with random operands; lead_opens starts it deep.
    task automatic send_well_formed(input int max_len, input int max_nest, input int lead_opens);
        logic [SYMBOL_W-1:0] chars[$];
        int depth;
        int count;
        int pick;
        depth = lead_opens;
        repeat (lead_opens) chars.push_back(SYM_OPEN);
        count = $urandom_range(1, max_len);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2 && depth < max_nest) begin
                chars.push_back(SYM_OPEN);
                depth++;
            end else if (pick < 4 && depth > 0) begin
                chars.push_back(SYM_CLOSE);
                depth--;
            end else if (pick == 4) begin
                chars.push_back(SYM_SPACE);
            end else begin
                chars.push_back(random_operand());
            end
        end
        while (depth > 0) begin
            chars.push_back(SYM_CLOSE);
            depth--;
        end
        foreach (chars[i]) begin
            send_symbol(chars[i], i == chars.size() - 1);
        end
    endtask

    // Unbalanced or garbled characters; the last one still ends the formula.
    task automatic send_noise(input int max_len);
        int count;
        logic [SYMBOL_W-1:0] sym;
        count = $urandom_range(1, max_len);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 4))
                0: sym = SYM_OPEN;
                1: sym = SYM_CLOSE;
                2: sym = SYM_SPACE;
                3: sym = random_operand();
                default: sym = SYMBOL_W'($urandom_range(0, 255));
            endcase
            send_symbol(sym, i == count - 1);
        end
    endtask

    task automatic test_directed();
        // a and c are true, b is false.
        write_variables(26'h0000005);
        send_text("a");
        send_text("(a c)");
        // Empty bracket alone, and folded into a filled entry.
        send_text("()");
        send_text("a()");
        // A close with only the bottom entry in use does nothing.
        send_text(")b");
        // Characters that are not letters read 0.
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        send_text("`{z");
        send_text("a ");
        send_text(" ");
    endtask

    task automatic test_stack_limit();
        wait_idle();
        write_variables(26'h3FFFFFF);
        // Opens past the full stack are dropped and flag overflow.
        repeat (70) send_symbol(SYM_OPEN, 1'b0);
        send_text("a)))b");
        // Filling the stack exactly does not overflow.
        repeat (STACK_DEPTH - 1) send_symbol(SYM_OPEN, 1'b0);
        send_text("a");
        // The flag must be cleared by the previous end of formula.
        send_text("z");
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_request = 1'b1;
        sender_burst = 1'b1;
        repeat (30) send_well_formed(4, 2, 0);
        sender_burst = 1'b0;
    endtask

    task automatic test_random_formulas();
        logic [VAR_W-1:0] settings[4];
        int start_count;
        int pick;
        settings[0] = '0;
        settings[1] = 26'h3FFFFFF;
        settings[2] = VAR_W'($urandom_range(0, 26'h3FFFFFF));
        settings[3] = VAR_W'($urandom_range(0, 26'h3FFFFFF));
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_variables(settings[p]);
            start_count = symbols_sent;
            while (symbols_sent - start_count < 345) begin
                sender_burst = ($urandom_range(0, 5) == 0);
                pick = $urandom_range(0, 39);
                if (pick == 0) begin
                    send_well_formed(30, 72, $urandom_range(58, 70));
                end else if (pick < 32) begin
                    send_well_formed(12, 4, 0);
                end else begin
                    send_noise(8);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            eval_stack[i] = ENTRY_EMPTY;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_stack_limit();
        test_backpressure();
        test_random_formulas();
        wait_idle();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/nesev_pkg.sv
hw/rtl/nesev_stack.sv
hw/rtl/nand_expression_stack_evaluator_top.sv
sim/tb.sv
